// ----- rtl/rlegem_pkg.sv -----
// ----------------------------------------------------------------------------
// rlegem_pkg: shared types and constants for the RLE gradient edge map
// Register indexes, reset values, field widths and the character codes used
// by the core, the gradient unit and the port checker.
// ----------------------------------------------------------------------------
package rlegem_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_RUN_DEF   = 64;

    // Field widths
    localparam int PIX_W    = 2;
    localparam int LEN_W    = 7;
    localparam int CHAR_W   = 7;
    localparam int CFG_W_W  = 11;
    localparam int CFG_H_W  = 16;
    localparam int CFG_L_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd2;

    // Register reset values
    localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd2;
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = 16'd2;
    localparam logic [CFG_L_W-1:0] LEVELS_RST = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
    localparam logic [CHAR_W-1:0] CHAR_HASH  = 7'h23;

    // Gradient unit result
    typedef struct packed {
        logic [PIX_W-1:0]  gradient;
        logic [CHAR_W-1:0] char_code;
    } t_grad_res;

    // One output word
    typedef struct packed {
        logic [PIX_W-1:0]  gradient;
        logic [CHAR_W-1:0] char_code;
        logic              row_end;
        logic              image_end;
    } t_out_word;

endpackage

// ----- rtl/rlegem_grad.sv -----
// ----------------------------------------------------------------------------
// rlegem_grad: 2x2 window gradient and character lookup
// Takes the four window pixels and the level count, returns the largest of
// the halved horizontal and vertical sums and the two diagonal differences,
// with the matching display character.
// ----------------------------------------------------------------------------
module rlegem_grad
    import rlegem_pkg::*;
(
    input  logic [PIX_W-1:0]   i_p1,
    input  logic [PIX_W-1:0]   i_p2,
    input  logic [PIX_W-1:0]   i_p3,
    input  logic [PIX_W-1:0]   i_p4,
    input  logic [CFG_L_W-1:0] i_levels,
    output t_grad_res          o_res
);

    logic signed [3:0] a, b, c, d;
    logic signed [3:0] s_h, s_v, s_p, s_n;
    logic [3:0]        m_h, m_v, m_p, m_n;
    logic [1:0]        g_h, g_v, g_p, g_n;
    logic [1:0]        g_max;
    logic [CFG_L_W-1:0] lv;
    logic [1:0]        lv_m1;

    // Differences and sums of the window
    always_comb begin
        a   = $signed({2'b00, i_p1});
        b   = $signed({2'b00, i_p2});
        c   = $signed({2'b00, i_p3});
        d   = $signed({2'b00, i_p4});
        s_h = a - b + c - d;
        s_v = a - c + b - d;
        s_p = a - d;
        s_n = b - c;
        m_h = s_h[3] ? 4'(-s_h) : 4'(s_h);
        m_v = s_v[3] ? 4'(-s_v) : 4'(s_v);
        m_p = s_p[3] ? 4'(-s_p) : 4'(s_p);
        m_n = s_n[3] ? 4'(-s_n) : 4'(s_n);
        // halving the magnitude truncates toward zero
        g_h = m_h[2:1];
        g_v = m_v[2:1];
        g_p = m_p[1:0];
        g_n = m_n[1:0];
    end

    // Pick the maximum
    always_comb begin
        g_max = g_h;
        if (g_v > g_max) g_max = g_v;
        if (g_p > g_max) g_max = g_p;
        if (g_n > g_max) g_max = g_n;
    end

    // Map the gradient to a character for the level count
    always_comb begin
        if (i_levels < 3'd2) begin
            lv = 3'd2;
        end else if (i_levels > 3'd4) begin
            lv = 3'd4;
        end else begin
            lv = i_levels;
        end
        lv_m1 = 2'(lv - 3'd1);
        o_res.gradient = g_max;
        if (g_max == 2'd0) begin
            o_res.char_code = CHAR_SPACE;
        end else if (g_max >= lv_m1) begin
            o_res.char_code = CHAR_HASH;
        end else if (g_max == 2'd1) begin
            o_res.char_code = CHAR_DOT;
        end else begin
            o_res.char_code = CHAR_COLON;
        end
    end

endmodule

// ----- rtl/rle_image_gradient_edge_map_core.sv -----
// ----------------------------------------------------------------------------
// rle_image_gradient_edge_map_core: run-length decoder with 2x2 edge map
// Expands runs into a raster, keeps the previous row in a line memory and
// emits one gradient word per complete 2x2 window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one run word: grey value
//   and length. Lengths above MAX_RUN are cut to MAX_RUN.
//   Output channel (o_out_valid / i_out_stall) gives one word per output
//   pixel: gradient, character, row end, image end and a last-of-run mark.
//   Config channel (i_cfg_valid / o_cfg_ready) writes width, height and level
//   count by index; a write to one restarts the image. Write only while idle.
// Timing:
//   After a run is accepted, the pixel sequencer expands one pixel per cycle
//   through a single window/gradient unit, unless a receiver stall holds it,
//   then uses a closing step to release the last held word. The input is
//   stalled from acceptance until that closing step. Each word is held until
//   the next word of its run or the closing step shows whether it ends the
//   run, so it reaches the output register only at that later word or step.
//   When the receiver stalls, the output register holds its word and the
//   sequencer waits at the next pixel that would produce a result.
// Reset: clears config to width 2, height 2, four levels and restarts the
//   image. The line memory is not cleared; it is only read where written.
// ----------------------------------------------------------------------------
module rle_image_gradient_edge_map_core
    import rlegem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // run input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    input  logic [LEN_W-1:0]      i_run_length,
    // gradient output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_gradient,
    output logic [CHAR_W-1:0]     o_char_code,
    output logic                  o_row_end,
    output logic                  o_image_end,
    output logic                  o_run_last,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = $clog2(MAX_RUN + 1);

    // Configuration
    logic [CFG_W_W-1:0] r_cfg_width;
    logic [CFG_H_W-1:0] r_cfg_height;
    logic [CFG_L_W-1:0] r_cfg_levels;

    // Sequencer and image position
    logic               r_busy;
    logic [RW-1:0]      r_rem;
    logic [PIX_W-1:0]   r_pix;
    logic [CW-1:0]      r_col;
    logic [CFG_H_W-1:0] r_row;
    logic               r_full;
    logic [PIX_W-1:0]   r_left;
    logic [PIX_W-1:0]   r_upleft;

    // Line memory and its registered read
    logic [PIX_W-1:0]   r_line [MAX_WIDTH];
    logic [PIX_W-1:0]   r_up;
    logic [CW-1:0]      rd_addr;

    // Held word and output register
    logic               r_pend_valid;
    t_out_word          r_pend;
    logic               r_out_valid;
    t_out_word          r_out;
    logic               r_out_last;

    logic               cfg_wr;
    logic               in_acc;
    logic [CW-1:0]      last_col;
    logic [CFG_H_W-1:0] last_row;
    logic [RW-1:0]      len_eff;
    logic               more;
    logic               produce;
    logic               out_free;
    logic               step;
    logic               close;
    logic [CW-1:0]      n_col;
    logic               wrap;
    t_grad_res          grad;
    t_out_word          new_word;

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !r_busy;
    assign o_in_stall  = r_busy;
    assign in_acc      = i_in_valid && !r_busy;

    // Effective image size and run length, clamped
    always_comb begin
        if (r_cfg_width < 11'd2) begin
            last_col = CW'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(r_cfg_width - 11'd1);
        end
        if (r_cfg_height < 16'd2) begin
            last_row = 16'd1;
        end else begin
            last_row = r_cfg_height - 16'd1;
        end
        if (int'(i_run_length) > MAX_RUN) begin
            len_eff = RW'(MAX_RUN);
        end else begin
            len_eff = RW'(i_run_length);
        end
    end

    // Window gradient for the current pixel
    rlegem_grad u_grad (
        .i_p1     (r_upleft),
        .i_p2     (r_up),
        .i_p3     (r_left),
        .i_p4     (r_pix),
        .i_levels (r_cfg_levels),
        .o_res    (grad)
    );

    // Step control: advance one pixel unless a word has nowhere to go
    always_comb begin
        more     = r_busy && (r_rem != '0) && !r_full;
        produce  = (r_row != '0) && (r_col != '0);
        out_free = !r_out_valid || !i_out_stall;
        step     = more && (!produce || !r_pend_valid || out_free);
        close    = r_busy && !more && (!r_pend_valid || out_free);
        wrap     = (r_col == last_col);
        n_col    = wrap ? '0 : r_col + CW'(1);
        rd_addr  = step ? n_col : r_col;
        new_word.gradient  = grad.gradient;
        new_word.char_code = grad.char_code;
        new_word.row_end   = wrap;
        new_word.image_end = wrap && (r_row == last_row);
    end

    // Line memory: write the current pixel, prefetch the next column
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_line[r_col] <= r_pix;
        end
        r_up <= r_line[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_cfg_levels <= LEVELS_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_W_W-1:0];
                REG_HEIGHT: r_cfg_height <= i_cfg_data[CFG_H_W-1:0];
                REG_LEVELS: r_cfg_levels <= i_cfg_data[CFG_L_W-1:0];
                default:    ;
            endcase
        end
    end

    // Sequencer and image position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rem    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_full   <= 1'b0;
            r_left   <= '0;
            r_upleft <= '0;
        end else begin
            if (cfg_wr && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT ||
                           i_cfg_index == REG_LEVELS)) begin
                r_col    <= '0;
                r_row    <= '0;
                r_full   <= 1'b0;
                r_left   <= '0;
                r_upleft <= '0;
            end
            if (in_acc) begin
                r_busy <= 1'b1;
                r_rem  <= len_eff;
            end else if (close) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_rem    <= r_rem - RW'(1);
                r_upleft <= r_up;
                r_left   <= r_pix;
                r_col    <= n_col;
                if (wrap) begin
                    if (r_row == last_row) begin
                        r_full <= 1'b1;
                    end else begin
                        r_row <= r_row + 16'd1;
                    end
                end
            end
        end
    end

    // Run value
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix <= i_pixel_value;
        end
    end

    // Hold the newest word; release it when a later one or the run end arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (step && produce) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end else if (out_free) begin
                    r_out_valid <= 1'b0;
                end
            end else if (close && r_pend_valid) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word payloads
    always_ff @(posedge i_clk) begin
        if (step && produce) begin
            r_pend <= new_word;
            if (r_pend_valid) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (close && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gradient  = r_out.gradient;
    assign o_char_code = r_out.char_code;
    assign o_row_end   = r_out.row_end;
    assign o_image_end = r_out.image_end;
    assign o_run_last  = r_out_last;

endmodule

// ----- rtl/rlegem_chk.sv -----
// ----------------------------------------------------------------------------
// rlegem_chk: port checker for the RLE gradient edge map core
// Watches the top level ports and flags words that break the output rules.
// ----------------------------------------------------------------------------
module rlegem_chk
    import rlegem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic [PIX_W-1:0]      o_gradient,
    input  logic [CHAR_W-1:0]     o_char_code,
    input  logic                  o_row_end,
    input  logic                  o_image_end,
    input  logic                  o_run_last,
    input  logic                  o_cfg_ready
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_gradient) && $stable(o_char_code) &&
            $stable(o_row_end) && $stable(o_image_end) && $stable(o_run_last))
        else $error("output word changed while stalled");

    // The image ends only at a row end
    a_img_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_end |-> o_row_end)
        else $error("image end without row end");

    // Zero gradient shows as space, any other never does
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_gradient == 2'd0) == (o_char_code == CHAR_SPACE)))
        else $error("character does not match gradient");

    // A run in progress blocks the next run and config writes
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !o_cfg_ready)
        else $error("new run or config taken during a run");

    // Gradient of three always shows as hash
    a_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_gradient == 2'd3 |-> o_char_code == CHAR_HASH)
        else $error("full gradient not shown as hash");

endmodule

bind rle_image_gradient_edge_map_core rlegem_chk u_rlegem_chk (.*);
